FILE: design/lhg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lhg_pkg;

    // number format
    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 20;
    localparam int DT_W      = FRAC_BITS + 1;
    localparam int MUL_W     = WORD_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int EXT_W     = PROD_W + 1;
    localparam int IDX_W     = 3;

    // reset values, rounded to nearest
    localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [WORD_W-1:0] RST_A     = WORD_W'(10 * ONE_FX);
    localparam logic signed [WORD_W-1:0] RST_R     = WORD_W'(28 * ONE_FX);
    localparam logic signed [WORD_W-1:0] RST_C     = WORD_W'((267 * ONE_FX + 50) / 100);
    localparam logic [DT_W-1:0]          RST_DT    = DT_W'((ONE_FX + 50) / 100);
    localparam logic signed [WORD_W-1:0] RST_START = WORD_W'((ONE_FX + 5) / 10);

    // request commands
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_RESTART = 2'd1;
    localparam logic [1:0] CMD_LOAD    = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_COEF_A       = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_R       = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_C       = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP_SIZE    = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_X      = 3'd4;
    localparam logic [IDX_W-1:0] REG_START_Y      = 3'd5;
    localparam logic [IDX_W-1:0] REG_START_Z      = 3'd6;
    localparam logic [IDX_W-1:0] REG_EMIT_ON_LOAD = 3'd7;

    // item start operations
    localparam logic [2:0] SO_NONE      = 3'd0;
    localparam logic [2:0] SO_TICK      = 3'd1;
    localparam logic [2:0] SO_RESTART   = 3'd2;
    localparam logic [2:0] SO_LOAD      = 3'd3;
    localparam logic [2:0] SO_LOAD_EMIT = 3'd4;

    // multiplier operand a
    localparam logic [1:0] MA_COEF_A = 2'd0;
    localparam logic [1:0] MA_EX     = 2'd1;
    localparam logic [1:0] MA_EZ     = 2'd2;
    localparam logic [1:0] MA_DT     = 2'd3;

    // multiplier operand b
    localparam logic [3:0] MB_T1     = 4'd0;
    localparam logic [3:0] MB_T2     = 4'd1;
    localparam logic [3:0] MB_EY     = 4'd2;
    localparam logic [3:0] MB_COEF_C = 4'd3;
    localparam logic [3:0] MB_FX     = 4'd4;
    localparam logic [3:0] MB_FY     = 4'd5;
    localparam logic [3:0] MB_FZ     = 4'd6;
    localparam logic [3:0] MB_SUM_X  = 4'd7;
    localparam logic [3:0] MB_SUM_Y  = 4'd8;
    localparam logic [3:0] MB_SUM_Z  = 4'd9;

    // product writeback
    localparam logic [3:0] WB_NONE = 4'd0;
    localparam logic [3:0] WB_DX   = 4'd1;
    localparam logic [3:0] WB_DY   = 4'd2;
    localparam logic [3:0] WB_T3   = 4'd3;
    localparam logic [3:0] WB_DZ   = 4'd4;
    localparam logic [3:0] WB_EX   = 4'd5;
    localparam logic [3:0] WB_EY   = 4'd6;
    localparam logic [3:0] WB_EZ   = 4'd7;
    localparam logic [3:0] WB_PX   = 4'd8;
    localparam logic [3:0] WB_PY   = 4'd9;
    localparam logic [3:0] WB_PZ   = 4'd10;

    typedef struct packed {
        logic [2:0] start_op;
        logic       diff;
        logic [1:0] mul_a;
        logic [3:0] mul_b;
        logic [3:0] wb_op;
        logic       dset;
        logic       half;
        logic       put;
    } lhg_cmd_t;

    typedef struct packed {
        logic emit_on_load;
    } lhg_status_t;

endpackage

`default_nettype wire

FILE: design/lhg_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lhg_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          cmd;
    logic signed [lhg_pkg::WORD_W-1:0]   load_x;
    logic signed [lhg_pkg::WORD_W-1:0]   load_y;
    logic signed [lhg_pkg::WORD_W-1:0]   load_z;

    modport source (output valid, output cmd, output load_x, output load_y,
                    output load_z, input ready);
    modport sink (input valid, input cmd, input load_x, input load_y,
                  input load_z, output ready);
endinterface

`default_nettype wire

FILE: design/lhg_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lhg_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [lhg_pkg::WORD_W-1:0]   out_x;
    logic signed [lhg_pkg::WORD_W-1:0]   out_y;
    logic signed [lhg_pkg::WORD_W-1:0]   out_z;

    modport source (output valid, output out_x, output out_y, output out_z,
                    input ready);
    modport sink (input valid, input out_x, input out_y, input out_z,
                  output ready);
endinterface

`default_nettype wire

FILE: design/lorenz_heun_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Lorenz chaotic noise source in signed fixed point (32-bit words, FRAC_BITS
// fraction bits). A tick request emits the current point (x, y, z) and then
// advances it by one Heun step; a restart request copies the start registers
// into the point; a load request overwrites the point and, with emit_on_load
// set, also emits and steps. Products round to nearest and every result
// saturates. A restart or plain load is done on acceptance. A request that
// emits holds the request side through the Heun sequence, whose fourteen
// products all go through the one 33x33 multiplier, until the result moves
// into the output register. The result register frees the request side, so
// the next request is taken while a result waits. The user writes registers
// through wr_en / wr_index / wr_data only while no request is in progress,
// not enforced here; start register writes take effect at the next restart.

module lorenz_heun_generator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    lhg_req_if.sink                         req,
    lhg_res_if.source                       res,
    input  wire logic                       wr_en,
    input  wire logic [lhg_pkg::IDX_W-1:0]  wr_index,
    input  wire logic [lhg_pkg::WORD_W-1:0] wr_data
);
    import lhg_pkg::*;

    lhg_cmd_t    ctl;
    lhg_status_t status;

    lhg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .status    (status),
        .ctl       (ctl)
    );

    lhg_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .status   (status),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .load_x   (req.load_x),
        .load_y   (req.load_y),
        .load_z   (req.load_z),
        .out_x    (res.out_x),
        .out_y    (res.out_y),
        .out_z    (res.out_z)
    );

endmodule

`default_nettype wire

FILE: design/lhg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lhg_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lhg_pkg::lhg_cmd_t                 ctl,
    output lhg_pkg::lhg_status_t                   status,
    input  wire logic                              wr_en,
    input  wire logic [lhg_pkg::IDX_W-1:0]         wr_index,
    input  wire logic [lhg_pkg::WORD_W-1:0]        wr_data,
    input  wire logic signed [lhg_pkg::WORD_W-1:0] load_x,
    input  wire logic signed [lhg_pkg::WORD_W-1:0] load_y,
    input  wire logic signed [lhg_pkg::WORD_W-1:0] load_z,
    output logic signed [lhg_pkg::WORD_W-1:0]      out_x,
    output logic signed [lhg_pkg::WORD_W-1:0]      out_y,
    output logic signed [lhg_pkg::WORD_W-1:0]      out_z
);
    import lhg_pkg::*;

    localparam logic signed [EXT_W-1:0] RND_ONE  = EXT_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [EXT_W-1:0] RND_HALF = EXT_W'(1) <<< FRAC_BITS;

    function automatic logic signed [EXT_W-1:0] ext(input logic signed [WORD_W-1:0] a);
        return {{(EXT_W - WORD_W){a[WORD_W-1]}}, a};
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [EXT_W-1:0] v);
        logic signed [WORD_W-1:0] res;
        if (&v[EXT_W-1:WORD_W-1] || ~|v[EXT_W-1:WORD_W-1])
        begin
            res = v[WORD_W-1:0];
        end
        else if (v[EXT_W-1])
        begin
            res = {1'b1, {(WORD_W - 1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(WORD_W - 1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [WORD_W-1:0] add_sat(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        return sat_word(ext(a) + ext(b));
    endfunction

    function automatic logic signed [WORD_W-1:0] sub_sat(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        return sat_word(ext(a) - ext(b));
    endfunction

    function automatic logic signed [MUL_W-1:0] widen(input logic signed [WORD_W-1:0] a);
        return {a[WORD_W-1], a};
    endfunction

    // configuration
    logic signed [WORD_W-1:0] coef_a_reg, coef_r_reg, coef_c_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [WORD_W-1:0] start_x_reg, start_y_reg, start_z_reg;
    logic                     emit_reg;

    // point, evaluation point, derivative sets (0 at point, 1 at predictor)
    logic signed [WORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [WORD_W-1:0] e_x_reg, e_y_reg, e_z_reg;
    logic signed [WORD_W-1:0] d_x_reg [2];
    logic signed [WORD_W-1:0] d_y_reg [2];
    logic signed [WORD_W-1:0] d_z_reg [2];
    logic signed [WORD_W-1:0] t1_reg, t2_reg, t3_reg;
    logic signed [WORD_W-1:0] snap_x_reg, snap_y_reg, snap_z_reg;
    logic signed [WORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [EXT_W-1:0]  prod_ext, rnd_full;
    logic signed [WORD_W-1:0] rnd_sat;

    assign status.emit_on_load = emit_reg;
    assign out_x = out_x_reg;
    assign out_y = out_y_reg;
    assign out_z = out_z_reg;

    always_comb
    begin
        unique case (ctl.mul_a)
            MA_COEF_A: mul_a = widen(coef_a_reg);
            MA_EX:     mul_a = widen(e_x_reg);
            MA_EZ:     mul_a = widen(e_z_reg);
            MA_DT:     mul_a = {{(MUL_W - DT_W){1'b0}}, dt_reg};
            default:   mul_a = '0;
        endcase
    end

    // heun sums of the two derivatives are kept exact
    always_comb
    begin
        unique case (ctl.mul_b)
            MB_T1:     mul_b = widen(t1_reg);
            MB_T2:     mul_b = widen(t2_reg);
            MB_EY:     mul_b = widen(e_y_reg);
            MB_COEF_C: mul_b = widen(coef_c_reg);
            MB_FX:     mul_b = widen(d_x_reg[0]);
            MB_FY:     mul_b = widen(d_y_reg[0]);
            MB_FZ:     mul_b = widen(d_z_reg[0]);
            MB_SUM_X:  mul_b = widen(d_x_reg[0]) + widen(d_x_reg[1]);
            MB_SUM_Y:  mul_b = widen(d_y_reg[0]) + widen(d_y_reg[1]);
            MB_SUM_Z:  mul_b = widen(d_z_reg[0]) + widen(d_z_reg[1]);
            default:   mul_b = '0;
        endcase
    end

    // round to nearest, ties up; half also folds in the divide by two
    assign prod_ext = {prod_reg[PROD_W-1], prod_reg};
    assign rnd_full = ctl.half ? ((prod_ext + RND_HALF) >>> (FRAC_BITS + 1))
                               : ((prod_ext + RND_ONE) >>> FRAC_BITS);
    assign rnd_sat  = sat_word(rnd_full);

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (ctl.diff)
        begin
            t1_reg <= sub_sat(e_y_reg, e_x_reg);
            t2_reg <= sub_sat(coef_r_reg, e_z_reg);
        end

        unique case (ctl.start_op)
            SO_TICK:
            begin
                e_x_reg    <= pos_x_reg;
                e_y_reg    <= pos_y_reg;
                e_z_reg    <= pos_z_reg;
                snap_x_reg <= pos_x_reg;
                snap_y_reg <= pos_y_reg;
                snap_z_reg <= pos_z_reg;
            end
            SO_LOAD_EMIT:
            begin
                e_x_reg    <= load_x;
                e_y_reg    <= load_y;
                e_z_reg    <= load_z;
                snap_x_reg <= load_x;
                snap_y_reg <= load_y;
                snap_z_reg <= load_z;
            end
            default:
            begin
            end
        endcase

        unique case (ctl.wb_op)
            WB_DX:   d_x_reg[ctl.dset] <= rnd_sat;
            WB_DY:   d_y_reg[ctl.dset] <= sub_sat(rnd_sat, e_y_reg);
            WB_T3:   t3_reg <= rnd_sat;
            WB_DZ:   d_z_reg[ctl.dset] <= sub_sat(t3_reg, rnd_sat);
            WB_EX:   e_x_reg <= add_sat(pos_x_reg, rnd_sat);
            WB_EY:   e_y_reg <= add_sat(pos_y_reg, rnd_sat);
            WB_EZ:   e_z_reg <= add_sat(pos_z_reg, rnd_sat);
            default:
            begin
            end
        endcase

        if (ctl.put)
        begin
            out_x_reg <= snap_x_reg;
            out_y_reg <= snap_y_reg;
            out_z_reg <= snap_z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg  <= RST_A;
            coef_r_reg  <= RST_R;
            coef_c_reg  <= RST_C;
            dt_reg      <= RST_DT;
            start_x_reg <= RST_START;
            start_y_reg <= RST_START;
            start_z_reg <= RST_START;
            emit_reg    <= 1'b0;
            pos_x_reg   <= RST_START;
            pos_y_reg   <= RST_START;
            pos_z_reg   <= RST_START;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_COEF_A:       coef_a_reg  <= wr_data;
                    REG_COEF_R:       coef_r_reg  <= wr_data;
                    REG_COEF_C:       coef_c_reg  <= wr_data;
                    REG_STEP_SIZE:    dt_reg      <= wr_data[DT_W-1:0];
                    REG_START_X:      start_x_reg <= wr_data;
                    REG_START_Y:      start_y_reg <= wr_data;
                    REG_START_Z:      start_z_reg <= wr_data;
                    REG_EMIT_ON_LOAD: emit_reg    <= wr_data[0];
                    default:
                    begin
                    end
                endcase
            end

            unique case (ctl.start_op) inside
                SO_RESTART:
                begin
                    pos_x_reg <= start_x_reg;
                    pos_y_reg <= start_y_reg;
                    pos_z_reg <= start_z_reg;
                end
                SO_LOAD, SO_LOAD_EMIT:
                begin
                    pos_x_reg <= load_x;
                    pos_y_reg <= load_y;
                    pos_z_reg <= load_z;
                end
                default:
                begin
                end
            endcase

            // final update adds the unsaturated rounded term
            unique case (ctl.wb_op)
                WB_PX:   pos_x_reg <= sat_word(ext(pos_x_reg) + rnd_full);
                WB_PY:   pos_y_reg <= sat_word(ext(pos_y_reg) + rnd_full);
                WB_PZ:   pos_z_reg <= sat_word(ext(pos_z_reg) + rnd_full);
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/lhg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lhg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic [1:0]           req_cmd,
    output logic                      req_ready,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    input  wire lhg_pkg::lhg_status_t status,
    output lhg_pkg::lhg_cmd_t         ctl
);
    import lhg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PUT  = 2'd2;

    localparam int         STEP_W    = 5;
    localparam logic [4:0] STEP_LAST = 5'd17;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic              accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = valid_reg;
    assign accept    = req_valid && req_ready;

    // heun schedule: most run steps issue one product and write back the previous one
    always_comb
    begin
        ctl          = '0;
        ctl.start_op = SO_NONE;
        ctl.mul_a    = MA_COEF_A;
        ctl.mul_b    = MB_T1;
        ctl.wb_op    = WB_NONE;
        state_next   = state_reg;
        step_next    = step_reg;
        valid_next   = valid_reg && !res_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    unique case (req_cmd)
                        CMD_TICK:
                        begin
                            ctl.start_op = SO_TICK;
                            state_next   = ST_RUN;
                        end
                        CMD_RESTART:
                        begin
                            ctl.start_op = SO_RESTART;
                        end
                        CMD_LOAD:
                        begin
                            if (status.emit_on_load)
                            begin
                                ctl.start_op = SO_LOAD_EMIT;
                                state_next   = ST_RUN;
                            end
                            else
                            begin
                                ctl.start_op = SO_LOAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_PUT;
                end
                unique case (step_reg)
                    5'd0, 5'd9:
                    begin
                        ctl.diff = 1'b1;
                    end
                    5'd1, 5'd10:
                    begin
                        ctl.mul_a = MA_COEF_A;
                        ctl.mul_b = MB_T1;
                    end
                    5'd2, 5'd11:
                    begin
                        ctl.mul_a = MA_EX;
                        ctl.mul_b = MB_T2;
                        ctl.wb_op = WB_DX;
                        ctl.dset  = (step_reg == 5'd11);
                    end
                    5'd3, 5'd12:
                    begin
                        ctl.mul_a = MA_EX;
                        ctl.mul_b = MB_EY;
                        ctl.wb_op = WB_DY;
                        ctl.dset  = (step_reg == 5'd12);
                    end
                    5'd4, 5'd13:
                    begin
                        ctl.mul_a = MA_EZ;
                        ctl.mul_b = MB_COEF_C;
                        ctl.wb_op = WB_T3;
                    end
                    5'd5:
                    begin
                        ctl.mul_a = MA_DT;
                        ctl.mul_b = MB_FX;
                        ctl.wb_op = WB_DZ;
                    end
                    5'd6:
                    begin
                        ctl.mul_a = MA_DT;
                        ctl.mul_b = MB_FY;
                        ctl.wb_op = WB_EX;
                    end
                    5'd7:
                    begin
                        ctl.mul_a = MA_DT;
                        ctl.mul_b = MB_FZ;
                        ctl.wb_op = WB_EY;
                    end
                    5'd8:
                    begin
                        ctl.wb_op = WB_EZ;
                    end
                    5'd14:
                    begin
                        ctl.mul_a = MA_DT;
                        ctl.mul_b = MB_SUM_X;
                        ctl.wb_op = WB_DZ;
                        ctl.dset  = 1'b1;
                    end
                    5'd15:
                    begin
                        ctl.mul_a = MA_DT;
                        ctl.mul_b = MB_SUM_Y;
                        ctl.wb_op = WB_PX;
                        ctl.half  = 1'b1;
                    end
                    5'd16:
                    begin
                        ctl.mul_a = MA_DT;
                        ctl.mul_b = MB_SUM_Z;
                        ctl.wb_op = WB_PY;
                        ctl.half  = 1'b1;
                    end
                    5'd17:
                    begin
                        ctl.wb_op = WB_PZ;
                        ctl.half  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_PUT:
            begin
                if (!valid_reg || res_ready)
                begin
                    ctl.put    = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_lorenz_heun_generator.sv
`timescale 1ns / 1ps

module tb_lorenz_heun_generator;
    import lhg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 22;
    localparam int LATENCY     = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_CAP   = 30;
    localparam longint WORD_MAX = (longint'(1) <<< (WORD_W - 1)) - 1;
    localparam longint WORD_MIN = -(longint'(1) <<< (WORD_W - 1));

    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] z;
    } point_t;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [WORD_W-1:0] wr_data;

    lhg_req_if req_ch ();
    lhg_res_if res_ch ();

    lorenz_heun_generator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .res      (res_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the registers and the point
    logic signed [WORD_W-1:0] cfg_a, cfg_r, cfg_c;
    logic [DT_W-1:0]          cfg_dt;
    logic signed [WORD_W-1:0] cfg_sx, cfg_sy, cfg_sz;
    logic                     cfg_emit;
    logic signed [WORD_W-1:0] pt_x, pt_y, pt_z;

    point_t expected_points[$];
    int mismatch_count = 0;
    int results_checked = 0;
    int settings_used = 0;
    int cmd_seen[4] = '{0, 0, 0, 0};
    bit steady = 1'b0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    function automatic longint sat_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // round to nearest, ties up; >>> on a signed longint is a floor
    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return sat_word(round_shr(a * b, FRAC_BITS));
    endfunction

    function automatic void lorenz_slope(input longint x, input longint y, input longint z,
                                         output longint dx, output longint dy,
                                         output longint dz);
        dx = fx_mul(cfg_a, sat_word(y - x));
        dy = sat_word(fx_mul(x, sat_word(cfg_r - z)) - y);
        dz = sat_word(fx_mul(x, y) - fx_mul(z, cfg_c));
    endfunction

    // sum of both slopes stays exact, the extra shift bit is the halving
    function automatic longint half_step(input longint p, input longint d0, input longint d1,
                                         input longint dt);
        return sat_word(p + round_shr(dt * (d0 + d1), FRAC_BITS + 1));
    endfunction

    function automatic void heun_advance();
        longint fx, fy, fz, gx, gy, gz, px, py, pz, dt;
        dt = longint'(cfg_dt);
        lorenz_slope(pt_x, pt_y, pt_z, fx, fy, fz);
        px = sat_word(pt_x + fx_mul(dt, fx));
        py = sat_word(pt_y + fx_mul(dt, fy));
        pz = sat_word(pt_z + fx_mul(dt, fz));
        lorenz_slope(px, py, pz, gx, gy, gz);
        pt_x = WORD_W'(half_step(pt_x, fx, gx, dt));
        pt_y = WORD_W'(half_step(pt_y, fy, gy, dt));
        pt_z = WORD_W'(half_step(pt_z, fz, gz, dt));
    endfunction

    function automatic void emit_point();
        expected_points.push_back('{pt_x, pt_y, pt_z});
        heun_advance();
    endfunction

    function automatic void apply_request(input logic [1:0] cmd,
                                          input logic signed [WORD_W-1:0] lx,
                                          input logic signed [WORD_W-1:0] ly,
                                          input logic signed [WORD_W-1:0] lz);
        case (cmd)
            CMD_TICK:
                emit_point();
            CMD_RESTART:
            begin
                pt_x = cfg_sx;
                pt_y = cfg_sy;
                pt_z = cfg_sz;
            end
            CMD_LOAD:
            begin
                pt_x = lx;
                pt_y = ly;
                pt_z = lz;
                if (cfg_emit)
                    emit_point();
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // request predictor and result checker
    always @(posedge clk)
    begin : result_check
        point_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                cmd_seen[req_ch.cmd]++;
                apply_request(req_ch.cmd, req_ch.load_x, req_ch.load_y, req_ch.load_z);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result (%h %h %h)",
                                              res_ch.out_x, res_ch.out_y, res_ch.out_z));
                end
                else
                begin
                    want = expected_points.pop_front();
                    results_checked++;
                    if (res_ch.out_x !== want.x)
                        report_mismatch($sformatf("out_x %h, want %h", res_ch.out_x, want.x));
                    if (res_ch.out_y !== want.y)
                        report_mismatch($sformatf("out_y %h, want %h", res_ch.out_y, want.y));
                    if (res_ch.out_z !== want.z)
                        report_mismatch($sformatf("out_z %h, want %h", res_ch.out_z, want.z));
                end
            end
        end
    end

    // result side ready, with random stalls and the long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_served)
        begin
            res_ch.ready <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end
        else
            res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("** lorenz_heun_generator: FAILED **");
        $finish;
    end

    task automatic send_req(input logic [1:0] cmd, input logic signed [WORD_W-1:0] lx,
                            input logic signed [WORD_W-1:0] ly,
                            input logic signed [WORD_W-1:0] lz);
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd;
        req_ch.load_x <= lx;
        req_ch.load_y <= ly;
        req_ch.load_z <= lz;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // the extra cycles pass idle after every expected result has been checked
    task automatic wait_drained(input int extra);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        case (idx)
            REG_COEF_A:       cfg_a = data;
            REG_COEF_R:       cfg_r = data;
            REG_COEF_C:       cfg_c = data;
            REG_STEP_SIZE:    cfg_dt = data[DT_W-1:0];
            REG_START_X:      cfg_sx = data;
            REG_START_Y:      cfg_sy = data;
            REG_START_Z:      cfg_sz = data;
            REG_EMIT_ON_LOAD: cfg_emit = data[0];
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers get random junk
    task automatic program_regs(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] r,
                                input logic [WORD_W-1:0] c, input logic [DT_W-1:0] dt,
                                input logic [WORD_W-1:0] sx, input logic [WORD_W-1:0] sy,
                                input logic [WORD_W-1:0] sz, input logic emit);
        logic [WORD_W-1:0] junk;
        junk = $urandom;
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_R, r);
        write_reg(REG_COEF_C, c);
        write_reg(REG_STEP_SIZE, {junk[WORD_W-1:DT_W], dt});
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_Z, sz);
        write_reg(REG_EMIT_ON_LOAD, {junk[WORD_W-1:1], emit});
        wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [WORD_W-1:0] near_attractor();
        return WORD_W'($urandom_range(0, 80 << FRAC_BITS)) - WORD_W'(40 << FRAC_BITS);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4, 5, 6: return near_attractor();
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_request();
        int pick;
        logic [1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 65)
            cmd = CMD_TICK;
        else if (pick < 85)
            cmd = CMD_LOAD;
        else if (pick < 93)
            cmd = CMD_RESTART;
        else
            cmd = CMD_UNUSED;
        send_req(cmd, pick_word(), pick_word(), pick_word());
    endtask

    task automatic program_random_setting();
        logic [WORD_W-1:0] a, r, c;
        logic [DT_W-1:0] dt;
        case ($urandom_range(2))
            0:
            begin
                a = RST_A;
                r = RST_R;
                c = RST_C;
                dt = $urandom_range(1) ? RST_DT : DT_W'($urandom_range(1, 20000));
            end
            1:
            begin
                a = $urandom_range(5 << FRAC_BITS, 15 << FRAC_BITS);
                r = $urandom_range(10 << FRAC_BITS, 50 << FRAC_BITS);
                c = $urandom_range(1 << FRAC_BITS, 4 << FRAC_BITS);
                dt = ($urandom_range(7) == 0) ? DT_W'(1 << FRAC_BITS)
                                              : DT_W'($urandom_range(1, 30000));
            end
            default:
            begin
                a = $urandom;
                r = $urandom;
                c = $urandom;
                dt = DT_W'($urandom);
            end
        endcase
        program_regs(a, r, c, dt, near_attractor(), near_attractor(), near_attractor(),
                     1'($urandom_range(1)));
    endtask

    task automatic test_reset_trajectory();
        repeat (4) send_req(CMD_TICK, '0, '0, '0);
        send_req(CMD_RESTART, '0, '0, '0);
        repeat (2) send_req(CMD_TICK, '0, '0, '0);
        wait_drained(LATENCY);
    endtask

    task automatic test_load_without_emit();
        send_req(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);
        send_req(CMD_TICK, '0, '0, '0);
        send_req(CMD_UNUSED, $urandom, $urandom, $urandom);
        send_req(CMD_TICK, '0, '0, '0);
        wait_drained(LATENCY);
    endtask

    // new start values must not move the point until a restart
    task automatic test_start_regs_and_emit();
        program_regs(RST_A, RST_R, RST_C, RST_DT, near_attractor(), near_attractor(),
                     near_attractor(), 1'b1);
        send_req(CMD_TICK, '0, '0, '0);
        send_req(CMD_LOAD, 32'sh8000_0000, 32'sh7FFF_FFFF, '0);
        send_req(CMD_LOAD, '1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_req(CMD_RESTART, '0, '0, '0);
        send_req(CMD_TICK, '0, '0, '0);
        wait_drained(LATENCY);
    endtask

    task automatic test_extreme_coefs();
        program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_req(CMD_LOAD, 32'sd1 <<< FRAC_BITS, 32'sd1 <<< FRAC_BITS, 32'sd1 <<< FRAC_BITS);
        repeat (2) send_req(CMD_TICK, '0, '0, '0);
        send_req(CMD_RESTART, '0, '0, '0);
        send_req(CMD_TICK, '0, '0, '0);
        wait_drained(LATENCY);
        program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, '0, 1'b0);
        send_req(CMD_RESTART, '0, '0, '0);
        repeat (2) send_req(CMD_TICK, '0, '0, '0);
        wait_drained(LATENCY);
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++)
        begin
            program_random_setting();
            steady = (phase == 2);
            repeat (220) send_random_request();
            wait_drained(LATENCY);
        end
        steady = 1'b0;
    endtask

    // result side holds off while requests keep coming, then the sender drains
    task automatic test_backpressure();
        program_regs(RST_A, RST_R, RST_C, RST_DT, RST_START, RST_START, RST_START, 1'b1);
        steady = 1'b1;
        hold_asked++;
        repeat (30) send_random_request();
        steady = 1'b0;
        wait_drained(0);
        repeat (30) send_random_request();
        wait_drained(LATENCY);
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_TICK;
        req_ch.load_x = '0;
        req_ch.load_y = '0;
        req_ch.load_z = '0;
        res_ch.ready = 1'b0;
        cfg_a = RST_A;
        cfg_r = RST_R;
        cfg_c = RST_C;
        cfg_dt = RST_DT;
        cfg_sx = RST_START;
        cfg_sy = RST_START;
        cfg_sz = RST_START;
        cfg_emit = 1'b0;
        pt_x = RST_START;
        pt_y = RST_START;
        pt_z = RST_START;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_trajectory();
        test_load_without_emit();
        test_start_regs_and_emit();
        test_extreme_coefs();
        test_random_phases();
        test_backpressure();
        wait_drained(LATENCY);

        $display("covered %0d ticks, %0d loads, %0d restarts, %0d unused commands",
                 cmd_seen[CMD_TICK], cmd_seen[CMD_LOAD], cmd_seen[CMD_RESTART],
                 cmd_seen[CMD_UNUSED]);
        $display("%0d points checked across %0d register settings, %0d mismatches",
                 results_checked, settings_used, mismatch_count);
        if (mismatch_count == 0)
            $display("** lorenz_heun_generator: PASSED **");
        else
            $display("** lorenz_heun_generator: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/lhg_pkg.sv
design/lhg_req_if.sv
design/lhg_res_if.sv
design/lhg_datapath.sv
design/lhg_ctrl.sv
design/lorenz_heun_generator.sv
tb/sv/tb_lorenz_heun_generator.sv
